>>> rtl/ljd_pkg.sv
`default_nettype none
package ljd_pkg;

  localparam int FRAC_BITS = 24;
  localparam int COORD_W   = 48;
  localparam int SHORT_W   = 32;
  localparam int DIST_W    = 47;
  localparam int PADDR_W   = 3;
  localparam int RF_DEPTH  = 32;
  localparam int RF_AW     = 5;
  localparam int PROG_LEN  = 91;
  localparam int PC_W      = 7;

  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] NMAX = -64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] K4   = 64'(4) << FRAC_BITS;
  localparam logic signed [63:0] K6   = 64'(6) << FRAC_BITS;
  localparam logic signed [63:0] K12  = 64'(12) << FRAC_BITS;
  localparam logic signed [63:0] K2   = 64'(2) << FRAC_BITS;
  localparam logic signed [63:0] KM3  = -(64'(3) << FRAC_BITS);

  localparam logic [PADDR_W-1:0] REG_DIPOLE_SCALE = '0;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NSQ0, OP_NSQ, OP_SQRT, OP_END, OP_DONE
  } alu_op_t;

  // operand / destination codes: below 32 is a scratch RAM address
  localparam logic [5:0] R_ELJ = 6'd0;
  localparam logic [5:0] R_G0  = 6'd1;
  localparam logic [5:0] R_G1  = 6'd2;
  localparam logic [5:0] R_G2  = 6'd3;
  localparam logic [5:0] R_F0  = 6'd4;
  localparam logic [5:0] R_F1  = 6'd5;
  localparam logic [5:0] R_F2  = 6'd6;
  localparam logic [5:0] R_T0  = 6'd7;
  localparam logic [5:0] R_T1  = 6'd8;
  localparam logic [5:0] R_T2  = 6'd9;
  localparam logic [5:0] R_T3  = 6'd10;
  localparam logic [5:0] R_T4  = 6'd11;
  localparam logic [5:0] R_T5  = 6'd12;
  localparam logic [5:0] R_S   = 6'd16;
  localparam logic [5:0] R_S2  = 6'd17;
  localparam logic [5:0] R_S6  = 6'd18;
  localparam logic [5:0] R_S12 = 6'd19;
  localparam logic [5:0] R_TA  = 6'd20;
  localparam logic [5:0] R_TB  = 6'd21;
  localparam logic [5:0] R_G   = 6'd22;
  localparam logic [5:0] R_LJD = 6'd23;
  localparam logic [5:0] R_R3  = 6'd24;
  localparam logic [5:0] R_R5  = 6'd25;
  localparam logic [5:0] R_E4  = 6'd27;
  localparam logic [5:0] R_E2  = 6'd28;

  localparam logic [5:0] SRC_OFFX = 6'd32;
  localparam logic [5:0] SRC_OFFY = 6'd33;
  localparam logic [5:0] SRC_OFFZ = 6'd34;
  localparam logic [5:0] SRC_D    = 6'd35;
  localparam logic [5:0] SRC_Q    = 6'd36;
  localparam logic [5:0] SRC_EPS  = 6'd37;
  localparam logic [5:0] SRC_SIG  = 6'd38;
  localparam logic [5:0] SRC_DIP  = 6'd39;
  localparam logic [5:0] SRC_K4   = 6'd40;
  localparam logic [5:0] SRC_K6   = 6'd41;
  localparam logic [5:0] SRC_K12  = 6'd42;
  localparam logic [5:0] SRC_KM3  = 6'd43;
  localparam logic [5:0] SRC_K2   = 6'd44;

  localparam logic [5:0] DST_D    = 6'd32;
  localparam logic [5:0] DST_E    = 6'd33;
  localparam logic [5:0] DST_FX   = 6'd34;
  localparam logic [5:0] DST_FY   = 6'd35;
  localparam logic [5:0] DST_FZ   = 6'd36;
  localparam logic [5:0] DST_NONE = 6'd37;

  typedef struct packed {
    alu_op_t    op;
    logic [5:0] dst;
    logic [5:0] sa;
    logic [5:0] sb;
  } uop_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EXEC, S_WAIT, S_OUT
  } seq_state_t;

  typedef enum logic [2:0] {
    A_IDLE, A_MUL, A_DIV, A_SQRT, A_FIN, A_DONE
  } alu_state_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  localparam uop_t PROG [PROG_LEN] = '{
    '{OP_NSQ0, DST_NONE, SRC_OFFX, SRC_OFFX},
    '{OP_NSQ,  DST_NONE, SRC_OFFY, SRC_OFFY},
    '{OP_NSQ,  DST_NONE, SRC_OFFZ, SRC_OFFZ},
    '{OP_SQRT, DST_D,    SRC_OFFX, SRC_OFFX},
    '{OP_MUL,  R_E4,  SRC_EPS, SRC_K4},
    '{OP_DIV,  R_S,   SRC_SIG, SRC_D},
    '{OP_MUL,  R_S2,  R_S,   R_S},
    '{OP_MUL,  R_S6,  R_S2,  R_S},
    '{OP_MUL,  R_S6,  R_S6,  R_S6},
    '{OP_MUL,  R_S12, R_S6,  R_S6},
    '{OP_SUB,  R_TA,  R_S12, R_S6},
    '{OP_MUL,  R_TA,  R_E4,  R_TA},
    '{OP_ADD,  R_ELJ, R_ELJ, R_TA},
    '{OP_MUL,  R_TA,  R_S6,  SRC_K6},
    '{OP_MUL,  R_TB,  R_S12, SRC_K12},
    '{OP_SUB,  R_TA,  R_TA,  R_TB},
    '{OP_DIV,  R_TA,  R_TA,  SRC_D},
    '{OP_DIV,  R_G,   R_TA,  SRC_D},
    '{OP_MUL,  R_LJD, R_E4,  R_G},
    '{OP_MUL,  R_TA,  R_LJD, SRC_OFFX},
    '{OP_ADD,  R_G0,  R_G0,  R_TA},
    '{OP_MUL,  R_TA,  R_LJD, SRC_OFFY},
    '{OP_ADD,  R_G1,  R_G1,  R_TA},
    '{OP_MUL,  R_TA,  R_LJD, SRC_OFFZ},
    '{OP_ADD,  R_G2,  R_G2,  R_TA},
    '{OP_DIV,  R_TA,  SRC_Q, SRC_D},
    '{OP_DIV,  R_TA,  R_TA,  SRC_D},
    '{OP_DIV,  R_R3,  R_TA,  SRC_D},
    '{OP_MUL,  R_TA,  R_R3,  SRC_KM3},
    '{OP_DIV,  R_TA,  R_TA,  SRC_D},
    '{OP_DIV,  R_R5,  R_TA,  SRC_D},
    '{OP_MUL,  R_TA,  R_R3,  SRC_OFFX},
    '{OP_ADD,  R_F0,  R_F0,  R_TA},
    '{OP_MUL,  R_TA,  R_R3,  SRC_OFFY},
    '{OP_ADD,  R_F1,  R_F1,  R_TA},
    '{OP_MUL,  R_TA,  R_R3,  SRC_OFFZ},
    '{OP_ADD,  R_F2,  R_F2,  R_TA},
    '{OP_MUL,  R_TA,  SRC_OFFX, SRC_OFFX},
    '{OP_MUL,  R_TA,  R_TA,  R_R5},
    '{OP_ADD,  R_TA,  R_R3,  R_TA},
    '{OP_ADD,  R_T0,  R_T0,  R_TA},
    '{OP_MUL,  R_TA,  SRC_OFFX, SRC_OFFY},
    '{OP_MUL,  R_TA,  R_TA,  R_R5},
    '{OP_ADD,  R_T1,  R_T1,  R_TA},
    '{OP_MUL,  R_TA,  SRC_OFFX, SRC_OFFZ},
    '{OP_MUL,  R_TA,  R_TA,  R_R5},
    '{OP_ADD,  R_T2,  R_T2,  R_TA},
    '{OP_MUL,  R_TA,  SRC_OFFY, SRC_OFFY},
    '{OP_MUL,  R_TA,  R_TA,  R_R5},
    '{OP_ADD,  R_TA,  R_R3,  R_TA},
    '{OP_ADD,  R_T3,  R_T3,  R_TA},
    '{OP_MUL,  R_TA,  SRC_OFFY, SRC_OFFZ},
    '{OP_MUL,  R_TA,  R_TA,  R_R5},
    '{OP_ADD,  R_T4,  R_T4,  R_TA},
    '{OP_MUL,  R_TA,  SRC_OFFZ, SRC_OFFZ},
    '{OP_MUL,  R_TA,  R_TA,  R_R5},
    '{OP_ADD,  R_TA,  R_R3,  R_TA},
    '{OP_ADD,  R_T5,  R_T5,  R_TA},
    '{OP_END,  DST_NONE, R_TA, R_TA},
    '{OP_MUL,  R_TA,  R_F0,  R_F0},
    '{OP_MUL,  R_TB,  R_F1,  R_F1},
    '{OP_ADD,  R_E2,  R_TA,  R_TB},
    '{OP_MUL,  R_TA,  R_F2,  R_F2},
    '{OP_ADD,  R_E2,  R_E2,  R_TA},
    '{OP_MUL,  R_TA,  SRC_DIP, R_E2},
    '{OP_SUB,  DST_E, R_ELJ, R_TA},
    '{OP_MUL,  R_TA,  R_F0,  R_T0},
    '{OP_MUL,  R_TB,  R_F1,  R_T1},
    '{OP_ADD,  R_TA,  R_TA,  R_TB},
    '{OP_MUL,  R_TB,  R_F2,  R_T2},
    '{OP_ADD,  R_TA,  R_TA,  R_TB},
    '{OP_MUL,  R_TA,  R_TA,  SRC_K2},
    '{OP_MUL,  R_TA,  SRC_DIP, R_TA},
    '{OP_SUB,  DST_FX, R_G0, R_TA},
    '{OP_MUL,  R_TA,  R_F0,  R_T1},
    '{OP_MUL,  R_TB,  R_F1,  R_T3},
    '{OP_ADD,  R_TA,  R_TA,  R_TB},
    '{OP_MUL,  R_TB,  R_F2,  R_T4},
    '{OP_ADD,  R_TA,  R_TA,  R_TB},
    '{OP_MUL,  R_TA,  R_TA,  SRC_K2},
    '{OP_MUL,  R_TA,  SRC_DIP, R_TA},
    '{OP_SUB,  DST_FY, R_G1, R_TA},
    '{OP_MUL,  R_TA,  R_F0,  R_T2},
    '{OP_MUL,  R_TB,  R_F1,  R_T4},
    '{OP_ADD,  R_TA,  R_TA,  R_TB},
    '{OP_MUL,  R_TB,  R_F2,  R_T5},
    '{OP_ADD,  R_TA,  R_TA,  R_TB},
    '{OP_MUL,  R_TA,  R_TA,  SRC_K2},
    '{OP_MUL,  R_TA,  SRC_DIP, R_TA},
    '{OP_SUB,  DST_FZ, R_G2, R_TA},
    '{OP_DONE, DST_NONE, R_TA, R_TA}
  };

  function automatic logic signed [63:0] sat_sign(input logic neg, input logic [63:0] m);
    logic [63:0] v;
    v = (m > 64'(SMAX)) ? 64'(SMAX) : m;
    return neg ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_7FFF_FFFF_FFFF;
    lo = -64'sh0000_8000_0000_0000;
    if (v > hi) return 48'sh7FFF_FFFF_FFFF;
    if (v < lo) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/ljd_if.sv
`default_nettype none
interface ljd_atom_if;
  import ljd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] atom_x;
  logic signed [COORD_W-1:0] atom_y;
  logic signed [COORD_W-1:0] atom_z;
  logic signed [COORD_W-1:0] probe_x;
  logic signed [COORD_W-1:0] probe_y;
  logic signed [COORD_W-1:0] probe_z;
  logic signed [SHORT_W-1:0] charge;
  logic [SHORT_W-1:0]        well_depth;
  logic [SHORT_W-1:0]        lj_sigma;
  logic                      last_atom;

  modport source (output valid, atom_x, atom_y, atom_z, probe_x, probe_y, probe_z,
                  charge, well_depth, lj_sigma, last_atom, input ready);
  modport sink (input valid, atom_x, atom_y, atom_z, probe_x, probe_y, probe_z,
                charge, well_depth, lj_sigma, last_atom, output ready);
endinterface

interface ljd_res_if;
  import ljd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] energy;
  logic [DIST_W-1:0]         max_distance;
  logic signed [COORD_W-1:0] force_x;
  logic signed [COORD_W-1:0] force_y;
  logic signed [COORD_W-1:0] force_z;

  modport source (output valid, energy, max_distance, force_x, force_y, force_z,
                  input ready);
  modport sink (input valid, energy, max_distance, force_x, force_y, force_z,
                output ready);
endinterface
`default_nettype wire

>>> rtl/lj_ion_dipole_potential_accumulator_core.sv
`default_nettype none
// Lennard-Jones 12-6 plus ion-induced-dipole accumulator for one probe point.
// Atoms arrive one request at a time on the atom channel; for each the core
// forms the signed, saturated offset atom minus probe, the integer square-root
// distance, and folds LJ energy and gradient, the ion field vector and the
// field-gradient tensor into 64-bit saturating accumulators (Q.24). The atom
// flagged last_atom produces one result request: energy = LJ - alpha*|E|^2,
// force = LJ gradient - 2*alpha*(T*E), the largest distance seen, all
// saturated to the port widths; the accumulators then clear. A zero distance
// saturates. alpha is the dipole_scale register at APB byte address 0; write
// it only while the core is idle.
// Structure: one sequencer walks a fixed microprogram through a single
// shared unit (4-part 32x32 multiplier, 128-step restoring divider, 48-step
// square root). An atom's time is dominated by its eight divisions. The
// atom channel is ready only while the sequencer is idle, so a new atom is
// taken only after the previous atom's microprogram has finished.
// A result waits in its output register and does not block the next atom.
module lj_ion_dipole_potential_accumulator_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ljd_atom_if.sink                           atom,
  ljd_res_if.source                          result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ljd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import ljd_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  logic [PC_W-1:0] pc;
  uop_t uop;

  // per-atom operands
  logic signed [COORD_W-1:0] off_x;
  logic signed [COORD_W-1:0] off_y;
  logic signed [COORD_W-1:0] off_z;
  logic signed [SHORT_W-1:0] q_r;
  logic [SHORT_W-1:0] eps_r;
  logic [SHORT_W-1:0] sig_r;
  logic last_r;
  logic [COORD_W-1:0] d_r;
  logic [COORD_W-1:0] largest;
  logic [31:0] dip_scale;

  // results staged by the microprogram
  logic signed [COORD_W-1:0] e_res;
  logic signed [COORD_W-1:0] fx_res;
  logic signed [COORD_W-1:0] fy_res;
  logic signed [COORD_W-1:0] fz_res;

  logic out_valid;
  logic out_load;

  logic signed [63:0] rd_a;
  logic signed [63:0] rd_b;
  logic signed [63:0] opa;
  logic signed [63:0] opb;
  logic rf_we;
  logic rf_clr;
  alu_ctl_t alu_ctl;
  logic alu_done;
  logic signed [63:0] alu_res;

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic signed [COORD_W:0] dz;

  assign uop = PROG[pc];

  function automatic logic signed [63:0] pick(input logic [5:0] code,
                                              input logic signed [63:0] ram);
    logic signed [63:0] v;
    v = ram;
    if (code[5]) begin
      unique case (code)
        SRC_OFFX: v = 64'(off_x);
        SRC_OFFY: v = 64'(off_y);
        SRC_OFFZ: v = 64'(off_z);
        SRC_D:    v = $signed({16'd0, d_r});
        SRC_Q:    v = 64'(q_r);
        SRC_EPS:  v = $signed({32'd0, eps_r});
        SRC_SIG:  v = $signed({32'd0, sig_r});
        SRC_DIP:  v = $signed({32'd0, dip_scale});
        SRC_K4:   v = K4;
        SRC_K6:   v = K6;
        SRC_K12:  v = K12;
        SRC_KM3:  v = KM3;
        SRC_K2:   v = K2;
        default:  v = '0;
      endcase
    end
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_off(input logic signed [COORD_W:0] v);
    if (v[COORD_W] != v[COORD_W-1]) begin
      return v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return v[COORD_W-1:0];
  endfunction

  assign opa = pick(uop.sa, rd_a);
  assign opb = pick(uop.sb, rd_b);

  assign dx = (COORD_W+1)'(atom.atom_x) - (COORD_W+1)'(atom.probe_x);
  assign dy = (COORD_W+1)'(atom.atom_y) - (COORD_W+1)'(atom.probe_y);
  assign dz = (COORD_W+1)'(atom.atom_z) - (COORD_W+1)'(atom.probe_z);

  ljd_regfile u_rf (
    .clk     (clk),
    .rst     (rst),
    .clr     (rf_clr),
    .we      (rf_we),
    .waddr   (uop.dst[RF_AW-1:0]),
    .wdata   (alu_res),
    .raddr_a (uop.sa[RF_AW-1:0]),
    .raddr_b (uop.sb[RF_AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  ljd_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alu_ctl),
    .a    (opa),
    .b    (opb),
    .done (alu_done),
    .res  (alu_res)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (atom.valid) state_next = S_FETCH;
      S_FETCH: begin
        // FETCH also launches the scratch RAM read for the operands
        priority if (uop.op == OP_END) state_next = last_r ? S_FETCH : S_IDLE;
        else if (uop.op == OP_DONE) state_next = S_OUT;
        else state_next = S_EXEC;
      end
      S_EXEC:  state_next = S_WAIT;
      S_WAIT:  if (alu_done) state_next = S_FETCH;
      S_OUT:   if (!out_valid || result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    atom.ready    = (state == S_IDLE);
    alu_ctl.start = (state == S_EXEC);
    alu_ctl.op    = uop.op;
    rf_we         = (state == S_WAIT) && alu_done && !uop.dst[5];
    out_load      = (state == S_OUT) && (!out_valid || result.ready);
    rf_clr        = out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      largest   <= '0;
      out_valid <= 1'b0;
      dip_scale <= '0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_DIPOLE_SCALE[PADDR_W-1]) begin
        dip_scale <= pwdata;
      end
      if (state == S_IDLE) begin
        pc <= '0;
      end else if ((state == S_FETCH && uop.op == OP_END) || (state == S_WAIT && alu_done)) begin
        pc <= pc + PC_W'(1);
      end
      if (state == S_WAIT && alu_done && uop.dst == DST_D) begin
        if (alu_res[COORD_W-1:0] > largest) largest <= alu_res[COORD_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
        largest   <= '0;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (atom.valid && atom.ready) begin
      off_x  <= sat_off(dx);
      off_y  <= sat_off(dy);
      off_z  <= sat_off(dz);
      q_r    <= atom.charge;
      eps_r  <= atom.well_depth;
      sig_r  <= atom.lj_sigma;
      last_r <= atom.last_atom;
    end
    if (state == S_WAIT && alu_done) begin
      unique case (uop.dst)
        DST_D:   d_r    <= alu_res[COORD_W-1:0];
        DST_E:   e_res  <= sat48(alu_res);
        DST_FX:  fx_res <= sat48(alu_res);
        DST_FY:  fy_res <= sat48(alu_res);
        DST_FZ:  fz_res <= sat48(alu_res);
        default: ;
      endcase
    end
    if (out_load) begin
      result.energy       <= e_res;
      result.force_x      <= fx_res;
      result.force_y      <= fy_res;
      result.force_z      <= fz_res;
      result.max_distance <= largest[COORD_W-1] ? {DIST_W{1'b1}} : largest[DIST_W-1:0];
    end
  end

  assign result.valid = out_valid;
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_DIPOLE_SCALE[PADDR_W-1]) ? dip_scale : 32'd0;
endmodule
`default_nettype wire

>>> rtl/ljd_regfile.sv
`default_nettype none
module ljd_regfile (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clr,
  input  wire logic                       we,
  input  wire logic [ljd_pkg::RF_AW-1:0]  waddr,
  input  wire logic signed [63:0]         wdata,
  input  wire logic [ljd_pkg::RF_AW-1:0]  raddr_a,
  input  wire logic [ljd_pkg::RF_AW-1:0]  raddr_b,
  output logic signed [63:0]              rdata_a,
  output logic signed [63:0]              rdata_b
);
  import ljd_pkg::*;

  logic signed [63:0] mem [RF_DEPTH];
  logic [RF_DEPTH-1:0] valid;
  logic signed [63:0] qa;
  logic signed [63:0] qb;
  logic va;
  logic vb;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= mem[raddr_a];
    qb <= mem[raddr_b];
  end

  // entries never written since the last clear read as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
      va    <= 1'b0;
      vb    <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      va <= valid[raddr_a];
      vb <= valid[raddr_b];
    end
  end

  assign rdata_a = va ? qa : '0;
  assign rdata_b = vb ? qb : '0;
endmodule
`default_nettype wire

>>> rtl/ljd_alu.sv
`default_nettype none
module ljd_alu (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ljd_pkg::alu_ctl_t   ctl,
  input  wire logic signed [63:0]  a,
  input  wire logic signed [63:0]  b,
  output logic                     done,
  output logic signed [63:0]       res
);
  import ljd_pkg::*;

  alu_state_t state;
  alu_state_t state_next;
  alu_op_t    op_r;
  logic signed [63:0] a_r;
  logic signed [63:0] b_r;
  logic        neg;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [6:0]  cnt;
  logic [63:0] pp;
  logic [1:0]  sh;
  logic [127:0] acc;
  logic [127:0] dv;
  logic [63:0]  rem;
  logic [63:0]  quo;
  logic         ovf;
  logic         bz;
  logic [95:0]  rad;
  logic [49:0]  srem;
  logic [47:0]  root;
  logic [97:0]  norm;

  logic [64:0]  rsh;
  logic         ge;
  logic [51:0]  rem2;
  logic [51:0]  trial;
  logic         sq_ge;
  logic signed [64:0] sum65;

  always_comb begin
    rsh   = {rem, dv[127]};
    ge    = rsh >= {1'b0, mb};
    rem2  = {srem, rad[95:94]};
    trial = {2'b00, root, 2'b01};
    sq_ge = rem2 >= trial;
    sum65 = (op_r == OP_SUB) ? (65'(a_r) - 65'(b_r)) : (65'(a_r) + 65'(b_r));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      A_IDLE: begin
        if (ctl.start) begin
          unique case (ctl.op)
            OP_MUL, OP_NSQ0, OP_NSQ: state_next = A_MUL;
            OP_DIV:                  state_next = A_DIV;
            OP_SQRT:                 state_next = A_SQRT;
            default:                 state_next = A_FIN;
          endcase
        end
      end
      A_MUL:  if (cnt == 7'd4) state_next = A_FIN;
      A_DIV:  if (cnt == 7'd127) state_next = A_FIN;
      A_SQRT: if (cnt == 7'd47) state_next = A_FIN;
      A_FIN:  state_next = A_DONE;
      A_DONE: state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  assign done = (state == A_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      norm  <= '0;
    end else begin
      state <= state_next;
      if (state == A_FIN && (op_r == OP_NSQ0 || op_r == OP_NSQ)) begin
        norm <= ((op_r == OP_NSQ0) ? 98'd0 : norm) + acc[97:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      A_IDLE: begin
        op_r <= ctl.op;
        a_r  <= a;
        b_r  <= b;
        cnt  <= '0;
        acc  <= '0;
        rem  <= '0;
        quo  <= '0;
        ovf  <= 1'b0;
        bz   <= (b == 64'sd0);
        srem <= '0;
        root <= '0;
        rad  <= norm[95:0];
        if (ctl.op == OP_NSQ0 || ctl.op == OP_NSQ) begin
          neg <= 1'b0;
          ma  <= mag64(a);
          mb  <= mag64(a);
        end else begin
          neg <= a[63] ^ b[63];
          ma  <= mag64(a);
          mb  <= mag64(b);
        end
        dv <= {64'd0, mag64(a)} << FRAC_BITS;
      end
      A_MUL: begin
        // four 32x32 partial products, each added in the cycle after it is formed
        if (cnt < 7'd4) begin
          pp <= (cnt[0] ? ma[63:32] : ma[31:0]) * (cnt[1] ? mb[63:32] : mb[31:0]);
          sh <= 2'(cnt[0]) + 2'(cnt[1]);
        end
        if (cnt != 7'd0) begin
          acc <= acc + ({64'd0, pp} << (32 * sh));
        end
        cnt <= cnt + 7'd1;
      end
      A_DIV: begin
        dv  <= dv << 1;
        rem <= ge ? 64'(rsh - {1'b0, mb}) : rsh[63:0];
        ovf <= ovf | quo[63];
        quo <= {quo[62:0], ge};
        cnt <= cnt + 7'd1;
      end
      A_SQRT: begin
        rad  <= rad << 2;
        srem <= sq_ge ? 50'(rem2 - trial) : rem2[49:0];
        root <= {root[46:0], sq_ge};
        cnt  <= cnt + 7'd1;
      end
      A_FIN: begin
        unique case (op_r)
          OP_ADD, OP_SUB: begin
            if (sum65 > 65'(SMAX)) res <= SMAX;
            else if (sum65 < 65'(NMAX)) res <= NMAX;
            else res <= sum65[63:0];
          end
          OP_MUL: begin
            if (|acc[127:64+FRAC_BITS]) res <= neg ? NMAX : SMAX;
            else res <= sat_sign(neg, acc[64+FRAC_BITS-1:FRAC_BITS]);
          end
          OP_DIV: begin
            if (bz) res <= (a_r == 64'sd0) ? 64'sd0 : (a_r[63] ? NMAX : SMAX);
            else if (ovf) res <= neg ? NMAX : SMAX;
            else res <= sat_sign(neg, quo);
          end
          OP_SQRT: res <= {16'd0, root};
          default: res <= '0;
        endcase
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> dv/ljd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ljd_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  ljd_atom_if              atom,
  ljd_res_if               result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [ljd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0] pwdata,
  output int               fail_count,
  output int               pending
);
  import ljd_pkg::*;

  localparam logic signed [63:0] TOP = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [47:0] energy;
    logic [46:0]        max_distance;
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
  } potential_t;

  potential_t         potentials[$];
  logic [31:0]        alpha;
  logic signed [63:0] lj_sum;
  logic signed [63:0] grad_sum[3];
  logic signed [63:0] field[3];
  logic signed [63:0] tens[6];
  logic [63:0]        far_dist;

  function automatic logic [63:0] magn(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

  function automatic logic signed [63:0] clip(input logic neg, input logic [63:0] m);
    logic signed [63:0] v;
    v = (m > 64'(TOP)) ? TOP : $signed(m);
    return neg ? -v : v;
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [127:0] p;
    p = {64'd0, magn(a)} * {64'd0, magn(b)};
    if ((p >> (64 + FRAC_BITS)) != 0) return (a[63] ^ b[63]) ? -TOP : TOP;
    return clip(a[63] ^ b[63], 64'(p >> FRAC_BITS));
  endfunction

  function automatic logic signed [63:0] qscale(input logic signed [63:0] a, input int k);
    return qmul(a, 64'(k) <<< FRAC_BITS);
  endfunction

  function automatic logic signed [63:0] qdiv(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic [127:0] q;
    if (b == 0) return (a > 0) ? TOP : ((a < 0) ? -TOP : 64'sd0);
    q = ({64'd0, magn(a)} << FRAC_BITS) / {64'd0, magn(b)};
    if (q > 128'(TOP)) return (a[63] ^ b[63]) ? -TOP : TOP;
    return clip(a[63] ^ b[63], q[63:0]);
  endfunction

  function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(TOP)) return TOP;
    if (s < -65'(TOP)) return -TOP;
    return s[63:0];
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
    if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -64'sh0000_8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t: %s got %h want %h", $time, what, got, want);
    fail_count++;
  endtask

  // fold one atom request into the sums; on the last atom push the expected result
  task automatic score_atom();
    logic signed [63:0] off[3];
    logic [127:0]       sq;
    logic [127:0]       t;
    logic signed [63:0] d, e4, s, s6, s12, g, ljd, r3, r5, e2, acc, f;
    logic [63:0]        r;
    potential_t         p;
    int                 rows[3][3];
    rows = '{'{0, 1, 2}, '{1, 3, 4}, '{2, 4, 5}};
    off[0] = 64'(clamp48(64'(atom.atom_x) - 64'(atom.probe_x)));
    off[1] = 64'(clamp48(64'(atom.atom_y) - 64'(atom.probe_y)));
    off[2] = 64'(clamp48(64'(atom.atom_z) - 64'(atom.probe_z)));
    sq = 0;
    for (int i = 0; i < 3; i++) sq += {64'd0, magn(off[i])} * {64'd0, magn(off[i])};
    r = 0;
    for (int i = 47; i >= 0; i--) begin
      t = 128'(r | (64'd1 << i));
      if (t * t <= sq) r = t[63:0];
    end
    d = $signed(r);
    if (r > far_dist) far_dist = r;
    e4 = qscale(64'(atom.well_depth), 4);
    s = qdiv(64'(atom.lj_sigma), d);
    s6 = qmul(qmul(s, s), s);
    s6 = qmul(s6, s6);
    s12 = qmul(s6, s6);
    lj_sum = qadd(lj_sum, qmul(e4, qadd(s12, -s6)));
    g = qdiv(qdiv(qadd(qscale(s6, 6), -qscale(s12, 12)), d), d);
    ljd = qmul(e4, g);
    for (int i = 0; i < 3; i++) grad_sum[i] = qadd(grad_sum[i], qmul(ljd, off[i]));
    r3 = qdiv(qdiv(qdiv(64'(atom.charge), d), d), d);
    r5 = qdiv(qdiv(qscale(r3, -3), d), d);
    for (int i = 0; i < 3; i++) field[i] = qadd(field[i], qmul(r3, off[i]));
    tens[0] = qadd(tens[0], qadd(r3, qmul(qmul(off[0], off[0]), r5)));
    tens[1] = qadd(tens[1], qmul(qmul(off[0], off[1]), r5));
    tens[2] = qadd(tens[2], qmul(qmul(off[0], off[2]), r5));
    tens[3] = qadd(tens[3], qadd(r3, qmul(qmul(off[1], off[1]), r5)));
    tens[4] = qadd(tens[4], qmul(qmul(off[1], off[2]), r5));
    tens[5] = qadd(tens[5], qadd(r3, qmul(qmul(off[2], off[2]), r5)));
    if (!atom.last_atom) return;
    e2 = qadd(qadd(qmul(field[0], field[0]), qmul(field[1], field[1])),
              qmul(field[2], field[2]));
    p.energy = clamp48(qadd(lj_sum, -qmul(64'(alpha), e2)));
    p.max_distance = (far_dist > 64'h7FFF_FFFF_FFFF) ? 47'h7FFF_FFFF_FFFF : far_dist[46:0];
    for (int i = 0; i < 3; i++) begin
      acc = qadd(qadd(qmul(field[0], tens[rows[i][0]]), qmul(field[1], tens[rows[i][1]])),
                 qmul(field[2], tens[rows[i][2]]));
      f = 64'(clamp48(qadd(grad_sum[i], -qmul(64'(alpha), qscale(acc, 2)))));
      if (i == 0) p.force_x = f[47:0];
      else if (i == 1) p.force_y = f[47:0];
      else p.force_z = f[47:0];
    end
    potentials.push_back(p);
    clear_sums();
  endtask

  task automatic clear_sums();
    lj_sum = 0;
    far_dist = 0;
    for (int i = 0; i < 3; i++) begin
      grad_sum[i] = 0;
      field[i] = 0;
    end
    for (int i = 0; i < 6; i++) tens[i] = 0;
  endtask

  task automatic check_result();
    potential_t p;
    if (potentials.size() == 0) begin
      report("unexpected result", 64'(result.energy), 64'd0);
      return;
    end
    p = potentials.pop_front();
    if (result.energy !== p.energy) report("energy", 64'(result.energy), 64'(p.energy));
    if (result.max_distance !== p.max_distance)
      report("max_distance", 64'(result.max_distance), 64'(p.max_distance));
    if (result.force_x !== p.force_x) report("force_x", 64'(result.force_x), 64'(p.force_x));
    if (result.force_y !== p.force_y) report("force_y", 64'(result.force_y), 64'(p.force_y));
    if (result.force_z !== p.force_z) report("force_z", 64'(result.force_z), 64'(p.force_z));
  endtask

  initial fail_count = 0;

  assign pending = potentials.size();

  always @(posedge clk) begin
    if (rst) begin
      alpha = 0;
      clear_sums();
      potentials.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_DIPOLE_SCALE) alpha = pwdata;
      if (result.valid && result.ready) check_result();
      if (atom.valid && atom.ready) score_atom();
    end
  end
endmodule
`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import ljd_pkg::*;

  localparam int  RANDOM_ATOMS = 1650;
  localparam int  PHASES       = 5;
  localparam int  CYCLE_LIMIT  = 25_000_000;
  localparam int  DRAIN_CYCLES = 2000;
  localparam logic signed [47:0] C_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] C_MIN = 48'sh8000_0000_0000;
  localparam logic signed [47:0] UNIT  = 48'sh1 <<< FRAC_BITS;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycles;
  bit          calm;     // no idling on either side while set

  ljd_atom_if atom_ch ();
  ljd_res_if  res_ch ();

  lj_ion_dipole_potential_accumulator_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .atom    (atom_ch),
    .result  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ljd_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .atom       (atom_ch),
    .result     (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop if the core hangs
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("lj_ion_dipole_potential_accumulator_core: mismatch");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // result sink: random stall before each result request
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // one atom request; valid stays high when the next one follows back to back
  task automatic send_atom(input logic [47:0] ax, ay, az, px, py, pz,
                           input logic [31:0] q, eps, sig, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      atom_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    atom_ch.valid      <= 1'b1;
    atom_ch.atom_x     <= ax;
    atom_ch.atom_y     <= ay;
    atom_ch.atom_z     <= az;
    atom_ch.probe_x    <= px;
    atom_ch.probe_y    <= py;
    atom_ch.probe_z    <= pz;
    atom_ch.charge     <= q;
    atom_ch.well_depth <= eps;
    atom_ch.lj_sigma   <= sig;
    atom_ch.last_atom  <= last;
    do @(posedge clk); while (!atom_ch.ready);
  endtask

  // wait until every expected result is back and the core has settled
  task automatic drain();
    atom_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_alpha(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DIPOLE_SCALE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // corner atoms: coincident atom and probe, saturating offsets, field extremes
  task automatic directed();
    send_atom(0, 0, 0, 0, 0, 0, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 1'b1);
    send_atom(UNIT, UNIT, 0, UNIT, UNIT, 0, 0, 0, 0, 1'b1);
    send_atom(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
              32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_atom(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
              32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_atom(C_MAX, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 32'hFFFF_FFFF, 1'b0);
    send_atom(0, C_MIN, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1'b1);
    send_atom(3 * UNIT, 0, 0, 0, 0, 0, 32'h0100_0000, 32'h0080_0000, 32'h0300_0000, 1'b0);
    send_atom(0, 2 * UNIT, 0, 0, 0, 0, 32'hFF00_0000, 32'h0080_0000, 32'h0200_0000, 1'b0);
    send_atom(0, 0, -4 * UNIT, 0, 0, 0, 32'h0080_0000, 32'h0100_0000, 32'h0380_0000, 1'b0);
    send_atom(UNIT, UNIT, UNIT, UNIT, UNIT, UNIT, 32'h0100_0000, 32'h0100_0000,
              32'h0100_0000, 1'b1);
    send_atom(1, 0, 0, 0, 0, 0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b1);
    send_atom(2 * UNIT, -UNIT, 2 * UNIT, 0, 0, 0, 32'hFFE0_0000, 32'h0040_0000,
              32'h0200_0000, 1'b1);
  endtask

  // queries around one probe; a few noise atoms with arbitrary fields
  task automatic random_queries(input int atoms);
    int          sent;
    int          n;
    logic [47:0] px, py, pz;
    sent = 0;
    while (sent < atoms) begin
      n  = $urandom_range(1, 6);
      px = 48'($signed($urandom()) <<< $urandom_range(0, 12));
      py = 48'($signed($urandom()) <<< $urandom_range(0, 12));
      pz = 48'($signed($urandom()) <<< $urandom_range(0, 12));
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_atom(rand48(), rand48(), rand48(), rand48(), rand48(), rand48(),
                    $urandom(), $urandom(), $urandom(), i == n - 1);
        end else begin
          send_atom(px + 48'($signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000),
                    py + 48'($signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000),
                    pz + 48'($signed($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000),
                    px, py, pz,
                    32'($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000),
                    $urandom_range(0, 32'h0200_0000),
                    $urandom_range(32'h0080_0000, 32'h0500_0000),
                    i == n - 1);
        end
        sent++;
      end
    end
  endtask

  initial begin
    logic [31:0] alphas[PHASES];
    alphas = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0100_0000, 32'h0000_0001, $urandom()};
    rst     <= 1'b1;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    calm    = 1'b0;
    atom_ch.valid      <= 1'b0;
    atom_ch.atom_x     <= '0;
    atom_ch.atom_y     <= '0;
    atom_ch.atom_z     <= '0;
    atom_ch.probe_x    <= '0;
    atom_ch.probe_y    <= '0;
    atom_ch.probe_z    <= '0;
    atom_ch.charge     <= '0;
    atom_ch.well_depth <= '0;
    atom_ch.lj_sigma   <= '0;
    atom_ch.last_atom  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_alpha(32'h0180_0000);
    directed();
    drain();
    for (int ph = 0; ph < PHASES; ph++) begin
      write_alpha(alphas[ph]);
      calm = (ph == 2);
      random_queries(RANDOM_ATOMS / PHASES);
      drain();
    end

    if (fail_count == 0) begin
      $display("lj_ion_dipole_potential_accumulator_core: match");
    end else begin
      $display("lj_ion_dipole_potential_accumulator_core: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
